@@ sv/dhkv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhkv_pkg
// Types, constants and codes shared by the double-hash key/value table.
// ----------------------------------------------------------------------------
package dhkv_pkg;

  localparam int unsigned DEPTH_DEF = 1024;
  localparam logic [9:0] TABLE_SIZE_RST = 10'd1021;
  localparam int unsigned ENTRY_W = 65;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_GET    = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UPDATED   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_READ,
    S_CHECK,
    S_DONE
  } fsm_t;

  localparam logic [0:0] REG_TABLE_SIZE = 1'd0;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [9:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic       busy;
    logic [9:0] rem;
  } div_rsp_t;

endpackage

@@ sv/dhkv_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhkv_req_if / dhkv_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface dhkv_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] key;
  logic [31:0] data_in;
  modport source (output valid, func, key, data_in, input ready);
  modport sink (input valid, func, key, data_in, output ready);
endinterface

interface dhkv_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_out;
  logic [1:0]  status;
  logic [10:0] entry_total;
  modport source (output valid, data_out, status, entry_total, input ready);
  modport sink (input valid, data_out, status, entry_total, output ready);
endinterface

@@ sv/dhkv_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhkv_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module dhkv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ sv/dhkv_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhkv_div
// Restoring remainder unit: 32-bit dividend by 10-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module dhkv_div
  import dhkv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [31:0] quo_r, quo_nxt;
  logic [10:0] rem_r, rem_nxt;
  logic [9:0]  dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [10:0] shifted;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    shifted = {rem_r[9:0], quo_r[31]};
    if (req.start) begin
      quo_nxt = req.dividend;
      rem_nxt = '0;
      dvs_nxt = req.divisor;
      cnt_nxt = 6'd32;
    end else if (cnt_r != 6'd0) begin
      quo_nxt = {quo_r[30:0], 1'b0};
      rem_nxt = (shifted >= {1'b0, dvs_r}) ? shifted - {1'b0, dvs_r} : shifted;
      cnt_nxt = cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy = (cnt_r != 6'd0);
  assign rsp.rem  = rem_r[9:0];

endmodule

@@ sv/dhkv_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhkv_ctrl
// Probe sequencer: hashes the key, walks the slot memory, writes back.
// ----------------------------------------------------------------------------
module dhkv_ctrl
  import dhkv_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [9:0]    table_size,
  dhkv_req_if.sink      req,
  dhkv_rsp_if.source    rsp
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned SW = AW + 1;

  fsm_t state_r, state_nxt;
  logic [1:0]  func_r, func_nxt;
  logic [31:0] key_r, key_nxt;
  logic [31:0] dat_r, dat_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [SW-1:0] size_r, size_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] probes_r, probes_nxt;
  logic        phase_r, phase_nxt;
  logic [31:0] res_r, res_nxt;
  logic [1:0]  st_r, st_nxt;
  logic        out_v_r, out_v_nxt;
  logic [AW-1:0] clr_r, clr_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic        s_act;
  logic [31:0] s_key, s_dat;
  logic [SW:0] pos_sum;
  logic [SW-1:0] eff;
  div_req_t    dreq;
  div_rsp_t    drsp;

  dhkv_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  dhkv_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign s_act = ram_rdata[64];
  assign s_key = ram_rdata[63:32];
  assign s_dat = ram_rdata[31:0];

  always_comb begin
    eff = SW'(table_size);
    if ({1'b0, table_size} < 11'd3) eff = SW'(3);
    if (32'(table_size) > 32'(DEPTH)) eff = SW'(DEPTH);
  end

  assign pos_sum = {1'b0, {1'b0, pos_r} + step_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (req.valid && !out_v_r) state_nxt = S_DIV;
      S_DIV:   if (!drsp.busy && phase_r) state_nxt = S_READ;
      S_READ:  state_nxt = S_CHECK;
      S_CHECK: begin
        state_nxt = S_READ;
        case (func_r)
          FUNC_INSERT: if (cnt_r >= size_r || probes_r == size_r || !s_act ||
                           s_key == key_r) state_nxt = S_DONE;
          FUNC_REMOVE: if (probes_r == size_r || s_dat == 32'd0 || s_key == key_r)
                         state_nxt = S_DONE;
          FUNC_GET:    if (cnt_r == '0 || probes_r == size_r || s_dat == 32'd0 ||
                           s_key == key_r) state_nxt = S_DONE;
          default:     state_nxt = S_DONE;
        endcase
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    func_nxt = func_r; key_nxt = key_r; dat_nxt = dat_r; pos_nxt = pos_r;
    step_nxt = step_r; size_nxt = size_r; cnt_nxt = cnt_r; probes_nxt = probes_r;
    phase_nxt = phase_r; res_nxt = res_r; st_nxt = st_r; clr_nxt = clr_r;
    out_v_nxt = out_v_r && !rsp.ready;
    ram_we = 1'b0; ram_addr = pos_r; ram_wdata = ram_rdata;
    dreq.start = 1'b0; dreq.dividend = key_r; dreq.divisor = size_r[9:0];
    req.ready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1; ram_addr = clr_r; ram_wdata = '0;
        clr_nxt = clr_r + AW'(1);
      end
      S_IDLE: begin
        req.ready = !out_v_r;
        if (req.valid && !out_v_r) begin
          func_nxt = req.func; key_nxt = req.key; dat_nxt = req.data_in;
          size_nxt = eff; phase_nxt = 1'b0;
          dreq.start = 1'b1; dreq.dividend = req.key; dreq.divisor = eff[9:0];
        end
      end
      S_DIV: if (!drsp.busy) begin
        if (!phase_r) begin
          pos_nxt = AW'(drsp.rem);
          phase_nxt = 1'b1;
          dreq.start = 1'b1; dreq.divisor = size_r[9:0] - 10'd2;
        end else begin
          step_nxt = SW'(drsp.rem) + SW'(1);
          probes_nxt = '0; st_nxt = ST_NOT_FOUND; res_nxt = '0;
        end
      end
      S_CHECK: begin
        probes_nxt = probes_r + SW'(1);
        pos_nxt = (pos_sum >= {1'b0, size_r}) ? AW'(pos_sum - {1'b0, size_r})
                                              : AW'(pos_sum);
        case (func_r)
          FUNC_INSERT: begin
            if (cnt_r >= size_r || probes_r == size_r) begin
              st_nxt = ST_FULL;
            end else if (!s_act) begin
              ram_we = 1'b1; ram_wdata = {1'b1, key_r, dat_r};
              cnt_nxt = cnt_r + SW'(1); st_nxt = ST_OK;
            end else if (s_key == key_r) begin
              ram_we = 1'b1; ram_wdata = {1'b1, key_r, dat_r}; st_nxt = ST_UPDATED;
            end
          end
          FUNC_REMOVE: begin
            if (probes_r != size_r && s_dat != 32'd0 && s_key == key_r && s_act) begin
              ram_we = 1'b1; ram_wdata = {1'b0, s_key, s_dat};
              cnt_nxt = cnt_r - SW'(1); res_nxt = s_dat; st_nxt = ST_OK;
            end
          end
          FUNC_GET: begin
            if (cnt_r != '0 && probes_r != size_r && s_key == key_r && s_act) begin
              res_nxt = s_dat; st_nxt = ST_OK;
            end
          end
          default: ;
        endcase
      end
      S_DONE: out_v_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; cnt_r <= '0; out_v_r <= 1'b0; clr_r <= '0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; out_v_r <= out_v_nxt; clr_r <= clr_nxt;
    end
    func_r <= func_nxt; key_r <= key_nxt; dat_r <= dat_nxt; pos_r <= pos_nxt;
    step_r <= step_nxt; size_r <= size_nxt; probes_r <= probes_nxt;
    phase_r <= phase_nxt; res_r <= res_nxt; st_r <= st_nxt;
  end

  assign rsp.valid       = out_v_r;
  assign rsp.data_out    = res_r;
  assign rsp.status      = st_r;
  assign rsp.entry_total = 11'(cnt_r);

endmodule

@@ sv/double_hash_key_value_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_hash_key_value_table_unit
// Key/data table with open addressing and double hashing over one RAM.
// ----------------------------------------------------------------------------
// channel   dir  payload
// in_       in   func, key, data_in
// out_      out  data_out, status, entry_total
// cfg_      in   APB, table_size at 0x0
//
// Per request: two passes of the remainder unit, then per probe a RAM read and
// a check/write back, plus the steps that accept, close and present the result.
// After reset a clearing pass writes all DEPTH entries.
// A waiting result holds off the next request until taken.
// ----------------------------------------------------------------------------
module double_hash_key_value_table_unit
  import dhkv_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  dhkv_req_if.sink    in_req,
  dhkv_rsp_if.source  out_rsp,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [9:0] size_r;
  logic       hit;

  assign hit = cfg_paddr[2] == REG_TABLE_SIZE;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = hit ? {22'd0, size_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= TABLE_SIZE_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && hit) begin
      size_r <= cfg_pwdata[9:0];
    end
  end

  dhkv_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .table_size(size_r), .req(in_req), .rsp(out_rsp)
  );

endmodule

@@ test/tb_double_hash_key_value_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_hash_key_value_table_unit
// Self-checking bench for the double-hash key/data table: directed and random
// insert/remove/get requests over several table sizes, each result checked
// against a behavioural table model kept in the bench.
// ----------------------------------------------------------------------------
module tb_double_hash_key_value_table_unit
  import dhkv_pkg::*;
;

  localparam int unsigned TBL_DEPTH = 1024;

  typedef struct packed {
    logic [31:0] data_out;
    logic [1:0]  status;
    logic [10:0] entry_total;
  } rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  dhkv_req_if in_req ();
  dhkv_rsp_if out_rsp ();

  double_hash_key_value_table_unit #(.DEPTH(TBL_DEPTH)) uut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req.sink), .out_rsp(out_rsp.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  logic        mdl_active [TBL_DEPTH];
  logic [31:0] mdl_key [TBL_DEPTH];
  logic [31:0] mdl_data [TBL_DEPTH];
  logic [10:0] mdl_count;
  logic [9:0]  mdl_size;

  rsp_t        expected_rsp [$];
  int unsigned mismatches = 0;
  int unsigned rsp_seen = 0;
  int unsigned req_sent = 0;
  logic [31:0] used_keys [$];

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("FAIL double_hash_key_value_table_unit");
    $finish;
  end

  initial begin
    in_req.valid = 1'b0;
    in_req.func = '0;
    in_req.key = '0;
    in_req.data_in = '0;
    out_rsp.ready = 1'b0;
  end

  function automatic rsp_t predict_table_op(logic [1:0] fn, logic [31:0] k,
                                            logic [31:0] d);
    int unsigned s, pos, stp;
    rsp_t r;
    s = mdl_size;
    if (s < 3) s = 3;
    if (s > TBL_DEPTH) s = TBL_DEPTH;
    pos = k % s;
    stp = (k % (s - 2)) + 1;
    r.data_out = '0;
    r.status = ST_NOT_FOUND;
    if (fn == FUNC_INSERT) begin
      r.status = ST_FULL;
      if (mdl_count < s) begin
        for (int i = 0; i < s; i++) begin
          if (mdl_active[pos]) begin
            if (mdl_key[pos] == k) begin
              mdl_data[pos] = d;
              r.status = ST_UPDATED;
              break;
            end
          end else begin
            mdl_active[pos] = 1'b1;
            mdl_data[pos] = d;
            mdl_key[pos] = k;
            mdl_count++;
            r.status = ST_OK;
            break;
          end
          pos = (pos + stp >= s) ? pos + stp - s : pos + stp;
        end
      end
    end else if (fn == FUNC_REMOVE) begin
      for (int i = 0; i < s; i++) begin
        if (mdl_data[pos] == 0) break;
        if (mdl_key[pos] == k) begin
          if (mdl_active[pos]) begin
            mdl_active[pos] = 1'b0;
            mdl_count--;
            r.data_out = mdl_data[pos];
            r.status = ST_OK;
          end
          break;
        end
        pos = (pos + stp >= s) ? pos + stp - s : pos + stp;
      end
    end else if (fn == FUNC_GET) begin
      if (mdl_count != 0) begin
        for (int i = 0; i < s; i++) begin
          if (mdl_key[pos] == k) begin
            if (mdl_active[pos]) begin
              r.data_out = mdl_data[pos];
              r.status = ST_OK;
            end
            break;
          end
          if (mdl_data[pos] == 0) break;
          pos = (pos + stp >= s) ? pos + stp - s : pos + stp;
        end
      end
    end
    r.entry_total = mdl_count;
    return r;
  endfunction

  task automatic send_request(logic [1:0] fn, logic [31:0] k, logic [31:0] d);
    int unsigned gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.func <= fn;
    in_req.key <= k;
    in_req.data_in <= d;
    do @(posedge clk); while (!in_req.ready);
    expected_rsp.push_back(predict_table_op(fn, k, d));
    req_sent++;
  endtask

  // rsp ready: random stall per result, some results taken with no stall
  initial begin
    int unsigned stall;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_rsp.ready <= 1'b1;
      do @(posedge clk); while (!out_rsp.valid);
    end
  end

  always @(posedge clk) begin
    rsp_t got, exp_r;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      got.data_out = out_rsp.data_out;
      got.status = out_rsp.status;
      got.entry_total = out_rsp.entry_total;
      rsp_seen++;
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        exp_r = expected_rsp.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp data=%h st=%0d tot=%0d got data=%h st=%0d tot=%0d",
                     exp_r.data_out, exp_r.status, exp_r.entry_total,
                     got.data_out, got.status, got.entry_total);
        end
      end
    end
  end

  task automatic drain_results();
    in_req.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_table_size(logic [9:0] sz);
    drain_results();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {REG_TABLE_SIZE, 2'b00};
    cfg_pwdata <= {22'd0, sz};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    mdl_size = sz;
  endtask

  function automatic logic [31:0] pick_key();
    if (used_keys.size() != 0 && $urandom_range(0, 3) != 0)
      return used_keys[$urandom_range(0, used_keys.size() - 1)];
    return $urandom();
  endfunction

  task automatic test_directed();
    send_request(FUNC_GET, 32'd5, 32'd0);
    send_request(FUNC_REMOVE, 32'd5, 32'd0);
    send_request(FUNC_INSERT, 32'd0, 32'hFFFF_FFFF);
    send_request(FUNC_INSERT, 32'hFFFF_FFFF, 32'h0000_0001);
    send_request(FUNC_INSERT, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
    send_request(FUNC_INSERT, 32'd1021, 32'd0);
    send_request(FUNC_GET, 32'd1021, 32'd0);
    send_request(FUNC_REMOVE, 32'd1021, 32'd0);
    send_request(FUNC_GET, 32'hFFFF_FFFF, 32'd0);
    send_request(FUNC_REMOVE, 32'd0, 32'd0);
    send_request(FUNC_GET, 32'd0, 32'd0);
    send_request(FUNC_REMOVE, 32'd0, 32'd0);
    send_request(FUNC_NONE, 32'h1234_5678, 32'h5555_5555);
    send_request(FUNC_GET, 32'd2042, 32'd0);
    send_request(FUNC_INSERT, 32'd2042, 32'h0000_0007);
    send_request(FUNC_GET, 32'd2042, 32'd0);
  endtask

  task automatic test_small_full(logic [9:0] sz, int unsigned n);
    logic [31:0] k;
    write_table_size(sz);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 40);
      send_request(logic'($urandom_range(0, 1)) ? FUNC_INSERT :
                   2'($urandom_range(1, 3)), k,
                   $urandom_range(0, 4) == 0 ? 32'd0 : $urandom());
    end
  endtask

  task automatic test_random(int unsigned n);
    logic [1:0] fn;
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      fn = ($urandom_range(0, 19) == 0) ? FUNC_NONE : 2'($urandom_range(0, 2));
      k = pick_key();
      if (fn == FUNC_INSERT && used_keys.size() < 200) used_keys.push_back(k);
      send_request(fn, k, $urandom_range(0, 9) == 0 ? 32'd0 : $urandom());
      if (i == n / 2) drain_results();
    end
  endtask

  initial begin
    foreach (mdl_active[i]) begin
      mdl_active[i] = 1'b0;
      mdl_key[i] = '0;
      mdl_data[i] = '0;
    end
    mdl_count = '0;
    mdl_size = TABLE_SIZE_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(200);
    test_small_full(10'd5, 60);
    test_small_full(10'd0, 30);
    test_small_full(10'd1023, 20);
    write_table_size(10'd13);
    test_random(100);
    write_table_size(10'd1021);
    test_random(150);
    drain_results();
    $display("covered %0d requests and %0d results over sizes 1021, 5, 0, 1023, 13",
             req_sent, rsp_seen);
    if (mismatches == 0 && expected_rsp.size() == 0) begin
      $display("PASS double_hash_key_value_table_unit");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, expected_rsp.size());
      $display("FAIL double_hash_key_value_table_unit");
    end
    $finish;
  end

endmodule
